>>> rtl/gar3_pkg.sv
// Shared types and constants for the 3-D average restriction block.
`default_nettype none
package gar3_pkg;

	localparam int unsigned VB = 32;
	localparam int unsigned FB = 16;
	localparam int unsigned SUM_W = 36;

	typedef struct packed {
		logic signed [VB-1:0] fine_value;
		logic [VB-1:0]        fine_volume;
		logic [VB-1:0]        coarse_volume;
	} in_item_t;

	typedef struct packed {
		logic signed [VB-1:0] coarse_value;
		logic [5:0]           coarse_x;
		logic [5:0]           coarse_y;
		logic [5:0]           coarse_z;
		logic                 grid_done;
	} out_item_t;

	typedef enum logic [2:0] {
		REG_COARSEN_X = 3'd0,
		REG_COARSEN_Y = 3'd1,
		REG_COARSEN_Z = 3'd2,
		REG_SIZE_X    = 3'd3,
		REG_SIZE_Y    = 3'd4,
		REG_SIZE_Z    = 3'd5,
		REG_SCALE     = 3'd6
	} reg_idx_t;

	localparam logic [VB-1:0] CAP_POS = {1'b0, {(VB-1){1'b1}}};
	localparam logic [VB-1:0] CAP_NEG = {1'b1, {(VB-1){1'b0}}};

endpackage
`default_nettype wire

>>> rtl/gar3_div.sv
// Iterative saturating fixed-point divider: value / volume, one quotient bit per cycle.
`default_nettype none
module gar3_div
	import gar3_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [VB-1:0] num,
	input  wire logic [VB-1:0]        den,
	output logic                      done,
	output logic signed [VB-1:0]      quot
);
	localparam int unsigned QW = VB + FB;
	localparam int unsigned CW = $clog2(QW + 1);

	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [QW-1:0]   dvd_q;
	logic [VB-1:0]   rem_q;
	logic [QW-1:0]   q_q;
	logic [VB-1:0]   den_q;
	logic            neg_q;
	logic            zero_q;

	logic [VB:0]     rem_sh;
	logic            ge;
	logic [VB-1:0]   mag;
	logic [VB-1:0]   cap;
	logic [VB-1:0]   qm;

	assign rem_sh = {rem_q, dvd_q[QW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign mag    = num[VB-1] ? VB'(-num) : VB'(num);
	assign cap    = neg_q ? CAP_NEG : CAP_POS;

	always_comb begin
		if (zero_q)
			qm = (dvd_q == '0) ? '0 : cap;
		else if (q_q > QW'(cap))
			qm = cap;
		else
			qm = q_q[VB-1:0];
		quot = neg_q ? VB'(-qm) : qm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1) || zero_q) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {mag, {FB{1'b0}}};
			rem_q  <= '0;
			q_q    <= '0;
			den_q  <= den;
			neg_q  <= num[VB-1];
			zero_q <= (den == '0);
		end else if (busy_q && !zero_q) begin
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			rem_q <= ge ? VB'(rem_sh - {1'b0, den_q}) : rem_sh[VB-1:0];
			q_q   <= {q_q[QW-2:0], ge};
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("done while busy");
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n) start |-> !done)
		else $error("divider started while done");
endmodule
`default_nettype wire

>>> rtl/grid_average_restriction_3d_top.sv
// Top level of the 3-D average restriction (up to 2x2x2 fine cells per coarse cell) over a fine-cell stream.
// Plain mode: an accepted item passes S_RD and S_ACC, then one that only accumulates returns to
// idle; one that completes a block first passes S_MUL, S_FIN and S_OUT, where its result turns valid.
// Scale mode: S_DIV comes first and waits for the bit-serial divider (one quotient bit a cycle),
// which stops early on a zero fine volume; a pending result holds a completing item in its multiply.
// Reset clears position, configuration registers and handshake state; the sum memory is not cleared.
`default_nettype none
module grid_average_restriction_3d_top
	import gar3_pkg::*;
#(
	parameter int unsigned MAX_COARSE_X = 64,
	parameter int unsigned MAX_COARSE_Y = 64,
	parameter int unsigned MAX_COARSE_Z = 64
)(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	input  wire logic      cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [6:0] cfg_data
);
	localparam int unsigned XW = $clog2(MAX_COARSE_X) > 0 ? $clog2(MAX_COARSE_X) : 1;
	localparam int unsigned YW = $clog2(MAX_COARSE_Y) > 0 ? $clog2(MAX_COARSE_Y) : 1;
	localparam int unsigned DEPTH = MAX_COARSE_X * MAX_COARSE_Y;
	localparam int unsigned AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
	localparam int unsigned PW = 12;

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_ACC, S_MUL, S_FIN, S_OUT} st_t;
	st_t st_q;

	logic cx_q, cy_q, cz_q, scale_q;
	logic [6:0] szx_q, szy_q, szz_q;
	logic [PW-1:0] px_q, py_q, pz_q;

	logic [PW-1:0] sx, sy, sz, fx, fy, fz;
	logic [PW-1:0] px, py, pz;

	function automatic logic [PW-1:0] clampsz(input logic [6:0] v, input int unsigned mx);
		logic [PW-1:0] r;
		r = PW'(v);
		if (r == '0) r = PW'(1);
		if (r > PW'(mx)) r = PW'(mx);
		return r;
	endfunction

	assign sx = clampsz(szx_q, MAX_COARSE_X);
	assign sy = clampsz(szy_q, MAX_COARSE_Y);
	assign sz = clampsz(szz_q, MAX_COARSE_Z);
	assign fx = sx << cx_q;
	assign fy = sy << cy_q;
	assign fz = sz << cz_q;

	always_comb begin
		if (px_q >= fx || py_q >= fy || pz_q >= fz) begin
			px = '0; py = '0; pz = '0;
		end else begin
			px = px_q; py = py_q; pz = pz_q;
		end
	end

	logic [PW-1:0] ccx, ccy, ccz;
	logic first_c, last_c;
	assign ccx = px >> cx_q;
	assign ccy = py >> cy_q;
	assign ccz = pz >> cz_q;
	assign first_c = (!cx_q || !px[0]) && (!cy_q || !py[0]) && (!cz_q || !pz[0]);
	assign last_c  = (!cx_q ||  px[0]) && (!cy_q ||  py[0]) && (!cz_q ||  pz[0]);

	// per-item registers
	logic [XW-1:0] ix_q;
	logic [YW-1:0] iy_q;
	logic [5:0] ox_q, oy_q, oz_q;
	logic first_q, last_q, done_q;
	logic signed [VB-1:0] v_q;
	logic [VB-1:0] cvol_q;
	logic [1:0] nc_q;

	logic div_start, div_done;
	logic signed [VB-1:0] div_quot;

	gar3_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (in_data.fine_value),
		.den    (in_data.fine_volume),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sum memory
	logic signed [SUM_W-1:0] mem [DEPTH];
	logic signed [SUM_W-1:0] rd_q;
	logic [AW-1:0] addr;
	logic wr_en;
	logic signed [SUM_W-1:0] acc, term;

	assign addr = AW'(iy_q) * AW'(MAX_COARSE_X) + AW'(ix_q);
	assign term = SUM_W'(v_q) <<< (2'd3 - nc_q);
	assign acc  = first_q ? term : rd_q + term;
	assign wr_en = (st_q == S_ACC);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr] <= acc;
		rd_q <= mem[addr];
	end

	// result path
	logic signed [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] mag;
	logic neg_q;
	logic [SUM_W+15:0] plo_q;
	logic [SUM_W-1:0] mag_q;
	logic [SUM_W+VB-1:0] prod;
	logic [SUM_W+VB-1:0] r_full;
	logic [VB-1:0] rmag;
	logic [VB-1:0] cap;

	assign mag = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
	assign prod = (SUM_W+VB)'(plo_q) + ((SUM_W+VB)'(mag_q * cvol_q[VB-1:16]) << 16);
	assign cap = neg_q ? CAP_NEG : CAP_POS;
	assign r_full = scale_q ? (prod >> (FB + 3)) : (SUM_W+VB)'(mag_q >> 3);
	assign rmag = (r_full > (SUM_W+VB)'(cap)) ? cap : r_full[VB-1:0];

	assign div_start = (st_q == S_IDLE) && in_valid && in_ready && scale_q;
	assign in_ready  = (st_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
			cx_q <= 1'b1; cy_q <= 1'b1; cz_q <= 1'b1; scale_q <= 1'b0;
			szx_q <= 7'd64; szy_q <= 7'd64; szz_q <= 7'd64;
			px_q <= '0; py_q <= '0; pz_q <= '0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (cfg_we && cfg_index <= 3'(REG_SCALE)) begin
				case (reg_idx_t'(cfg_index))
					REG_COARSEN_X: cx_q <= cfg_data[0];
					REG_COARSEN_Y: cy_q <= cfg_data[0];
					REG_COARSEN_Z: cz_q <= cfg_data[0];
					REG_SIZE_X:    szx_q <= cfg_data;
					REG_SIZE_Y:    szy_q <= cfg_data;
					REG_SIZE_Z:    szz_q <= cfg_data;
					REG_SCALE:     scale_q <= cfg_data[0];
					default:       ;
				endcase
				px_q <= '0; py_q <= '0; pz_q <= '0;
			end
			case (st_q)
				S_IDLE: if (in_valid && in_ready) begin
					st_q <= scale_q ? S_DIV : S_RD;
					if (px + 1'b1 >= fx) begin
						px_q <= '0;
						if (py + 1'b1 >= fy) begin
							py_q <= '0;
							pz_q <= (pz + 1'b1 >= fz) ? '0 : pz + 1'b1;
						end else begin
							py_q <= py + 1'b1; pz_q <= pz;
						end
					end else begin
						px_q <= px + 1'b1; py_q <= py; pz_q <= pz;
					end
				end
				S_DIV: if (div_done) st_q <= S_RD;
				S_RD:  st_q <= S_ACC;
				S_ACC: st_q <= last_q ? S_MUL : S_IDLE;
				// wait here until the previous result has left the output register
				S_MUL: if (!out_valid || out_ready) st_q <= S_FIN;
				S_FIN: st_q <= S_OUT;
				S_OUT: begin
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (in_valid && in_ready) begin
				ix_q <= XW'(ccx);
				iy_q <= YW'(ccy);
				ox_q <= 6'(ccx); oy_q <= 6'(ccy); oz_q <= 6'(ccz);
				first_q <= first_c;
				last_q <= last_c;
				done_q <= (ccx == sx - 1'b1) && (ccy == sy - 1'b1) && (ccz == sz - 1'b1);
				v_q <= in_data.fine_value;
				cvol_q <= in_data.coarse_volume;
				nc_q <= 2'(cx_q) + 2'(cy_q) + 2'(cz_q);
			end
			S_DIV: if (div_done) v_q <= div_quot;
			S_ACC: acc_q <= acc;
			S_MUL: begin
				neg_q <= acc_q[SUM_W-1];
				mag_q <= mag;
				plo_q <= mag * cvol_q[15:0];
			end
			S_FIN: begin
				out_data.coarse_value <= neg_q ? VB'(-rmag) : rmag;
				out_data.coarse_x <= ox_q;
				out_data.coarse_y <= oy_q;
				out_data.coarse_z <= oz_q;
				out_data.grid_done <= done_q;
			end
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> st_q == S_IDLE) else $error("ready outside idle");
	a_no_wr_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && in_ready)) else $error("write while accepting");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && st_q == S_OUT)) else $error("result overrun");
endmodule
`default_nettype wire
